// ===== rtl/core/kca_pkg.sv =====
`default_nettype none

package kca_pkg;

	localparam int unsigned KEY_SLOTS = 16;
	localparam int unsigned IDX_W     = 4;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned DELAY_W   = 16;
	localparam int unsigned ADDR_W    = 3;

	typedef enum logic {
		CMD_SCAN   = 1'b0,
		CMD_FORGET = 1'b1
	} kca_cmd_t;

	typedef enum logic {
		REG_FIRST_DELAY  = 1'b0,
		REG_REPEAT_DELAY = 1'b1
	} kca_reg_t;

	localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = 16'd500;
	localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 16'd175;

	// key table: group select (1 = group 2 word) and bit mask
	localparam logic [KEY_SLOTS-1:0] KEY_GROUP2 = 16'b0011_1110_0000_0000;

	localparam logic [WORD_W-1:0] KEY_MASK [KEY_SLOTS] = '{
		32'h0000_0800, 32'h0000_1000, 32'h0000_2000, 32'h0000_4000,
		32'h0000_8000, 32'h0004_0000, 32'h0010_0000, 32'h0020_0000,
		32'h0008_0000, 32'h0000_0800, 32'h0000_8000, 32'h000c_0000,
		32'h0008_0000, 32'h0004_0000, 32'h0000_0000, 32'h0000_0000
	};

	typedef struct packed {
		logic              cmd;
		logic [WORD_W-1:0] keys_group0;
		logic [WORD_W-1:0] keys_group2;
		logic [WORD_W-1:0] now_ms;
	} kca_item_t;

	typedef struct packed {
		logic             key_valid;
		logic [IDX_W-1:0] key_index;
	} kca_res_t;

	typedef struct packed {
		logic [DELAY_W-1:0] first_delay_ms;
		logic [DELAY_W-1:0] repeat_delay_ms;
	} kca_cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] prev_word0;
		logic [WORD_W-1:0] prev_word2;
		logic [WORD_W-1:0] cur_word0;
		logic [WORD_W-1:0] cur_word2;
		logic              held_valid;
		logic [IDX_W-1:0]  held_index;
		logic [WORD_W-1:0] last_report_ms;
		logic              repeating;
	} kca_state_t;

	localparam kca_state_t STATE_RST = '{
		prev_word0:     '1,
		prev_word2:     '1,
		cur_word0:      '1,
		cur_word2:      '1,
		held_valid:     1'b0,
		held_index:     '0,
		last_report_ms: '0,
		repeating:      1'b0
	};

	function automatic logic [WORD_W-1:0] key_word(
		input logic [IDX_W-1:0]  idx,
		input logic [WORD_W-1:0] w0,
		input logic [WORD_W-1:0] w2
	);
		return KEY_GROUP2[idx] ? w2 : w0;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kca_ifs.sv =====
`default_nettype none

interface kca_in_if;
	import kca_pkg::*;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [WORD_W-1:0] keys_group0;
	logic [WORD_W-1:0] keys_group2;
	logic [WORD_W-1:0] now_ms;

	modport source (output valid, cmd, keys_group0, keys_group2, now_ms, input ready);
	modport sink   (input valid, cmd, keys_group0, keys_group2, now_ms, output ready);
endinterface

interface kca_out_if;
	import kca_pkg::*;
	logic             valid;
	logic             ready;
	logic             key_valid;
	logic [IDX_W-1:0] key_index;

	modport source (output valid, key_valid, key_index, input ready);
	modport sink   (input valid, key_valid, key_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kca_cfg.sv =====
`default_nettype none

module kca_cfg
	import kca_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output kca_cfg_t               cfg
);

	kca_cfg_t cfg_q;
	kca_reg_t sel;
	logic     wr_en;

	assign pready = 1'b1;
	assign sel    = kca_reg_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_delay_ms  <= FIRST_DELAY_RST;
			cfg_q.repeat_delay_ms <= REPEAT_DELAY_RST;
		end else if (wr_en) begin
			unique case (sel)
				REG_FIRST_DELAY:  cfg_q.first_delay_ms  <= pwdata[DELAY_W-1:0];
				REG_REPEAT_DELAY: cfg_q.repeat_delay_ms <= pwdata[DELAY_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_FIRST_DELAY:  prdata = {16'b0, cfg_q.first_delay_ms};
			REG_REPEAT_DELAY: prdata = {16'b0, cfg_q.repeat_delay_ms};
			default:          prdata = '0;
		endcase
	end

	// low address bits select nothing; registers are word aligned
	logic unused_addr;
	assign unused_addr = ^paddr[1:0];

endmodule

`default_nettype wire

// ===== rtl/core/kca_step.sv =====
`default_nettype none

module kca_step
	import kca_pkg::*;
#(
	parameter int unsigned KEY_COUNT = 14
) (
	input  kca_item_t  item,
	input  kca_state_t st,
	input  kca_cfg_t   cfg,
	output kca_state_t nxt,
	output kca_res_t   res
);

	localparam int unsigned SCAN_N = (KEY_COUNT < KEY_SLOTS) ? KEY_COUNT : KEY_SLOTS;

	logic [SCAN_N-1:0] click;
	logic              hit;
	logic [IDX_W-1:0]  hit_idx;
	logic              held_down;
	logic [WORD_W-1:0] elapsed;
	logic [DELAY_W-1:0] limit;

	// click: masked bits were not all low, now all low
	always_comb begin
		for (int i = 0; i < SCAN_N; i++) begin
			click[i] = ((key_word(IDX_W'(i), st.cur_word0, st.cur_word2)
				& KEY_MASK[i]) != '0)
				&& ((key_word(IDX_W'(i), item.keys_group0, item.keys_group2)
				& KEY_MASK[i]) == '0);
		end
	end

	// lowest index wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = SCAN_N - 1; i >= 0; i--) begin
			if (click[i]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign held_down = (key_word(st.held_index, item.keys_group0, item.keys_group2)
		& KEY_MASK[st.held_index]) == '0;
	assign elapsed   = item.now_ms - st.last_report_ms;
	assign limit     = st.repeating ? cfg.repeat_delay_ms : cfg.first_delay_ms;

	always_comb begin
		nxt = st;
		res = '0;
		if (kca_cmd_t'(item.cmd) == CMD_FORGET) begin
			nxt.held_valid = 1'b0;
		end else begin
			nxt.prev_word0 = st.cur_word0;
			nxt.prev_word2 = st.cur_word2;
			nxt.cur_word0  = item.keys_group0;
			nxt.cur_word2  = item.keys_group2;
			if (hit) begin
				nxt.held_valid     = 1'b1;
				nxt.held_index     = hit_idx;
				nxt.repeating      = 1'b0;
				nxt.last_report_ms = item.now_ms;
				res.key_valid      = 1'b1;
				res.key_index      = hit_idx;
			end else if (st.held_valid && held_down) begin
				if (elapsed > {16'b0, limit}) begin
					nxt.repeating      = 1'b1;
					nxt.last_report_ms = item.now_ms;
					res.key_valid      = 1'b1;
					res.key_index      = st.held_index;
				end
			end else begin
				nxt.held_valid = 1'b0;
				nxt.held_index = '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/key_click_autorepeat_top.sv =====
`default_nettype none
// A request accepted into the input register moves on into the output register
//   once that slot is free or draining, and is held there until taken.
// Throughput: one request per cycle while the result side is ready; the combinational step sets the rate.
// Reset (arst_n low, async): key words all ones, no held key, delays 500/175 ms,
//   input and output stages empty.

module key_click_autorepeat_top
	import kca_pkg::*;
#(
	parameter int unsigned KEY_COUNT = 14
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	kca_in_if.sink                 scan,
	kca_out_if.source              result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	// config registers
	kca_cfg_t cfg;

	kca_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register stage
	logic      valid_s1;
	kca_item_t item_s1;

	// output register stage
	logic     res_valid_q;
	kca_res_t res_q;

	// scan/repeat state
	kca_state_t st_q;
	kca_state_t st_nxt;
	kca_res_t   res_nxt;

	logic adv;

	// the stage-1 request moves on when the output slot is free or draining
	assign adv        = !res_valid_q || result.ready;
	assign scan.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			item_s1.cmd         <= scan.cmd;
			item_s1.keys_group0 <= scan.keys_group0;
			item_s1.keys_group2 <= scan.keys_group2;
			item_s1.now_ms      <= scan.now_ms;
		end
	end

	kca_step #(
		.KEY_COUNT (KEY_COUNT)
	) u_step (
		.item (item_s1),
		.st   (st_q),
		.cfg  (cfg),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	// state commits only when the request leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= STATE_RST;
			res_valid_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			st_q        <= st_nxt;
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.key_valid = res_q.key_valid;
	assign result.key_index = res_q.key_index;

endmodule

`default_nettype wire

// ===== tb/sv/tb_key_click_autorepeat_top.sv =====
`default_nettype none

module tb_key_click_autorepeat_top;
	import kca_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// run limits
	localparam int unsigned QUIET_LIMIT = 1000; // cycles with no handshake at all
	localparam int unsigned HOLD_AT     = 40;   // requests taken before the long back-pressure
	localparam int unsigned HOLD_LEN    = 60;   // cycles the result side stays not ready

	// key table, in scan order: mask and group (1 = group 2 word)
	localparam int unsigned       TBL_KEYS = 14;
	localparam logic [WORD_W-1:0] TBL_MASK [TBL_KEYS] = '{
		32'h0000_0800, 32'h0000_1000, 32'h0000_2000, 32'h0000_4000,
		32'h0000_8000, 32'h0004_0000, 32'h0010_0000, 32'h0020_0000,
		32'h0008_0000, 32'h0000_0800, 32'h0000_8000, 32'h000c_0000,
		32'h0008_0000, 32'h0004_0000
	};
	localparam logic [TBL_KEYS-1:0] TBL_G2 = 14'b11_1110_0000_0000;

	// all bits that belong to some key, per group
	localparam logic [WORD_W-1:0] KEYBITS0 = 32'h003c_f800;
	localparam logic [WORD_W-1:0] KEYBITS2 = 32'h000c_8800;

	logic clk = 1'b0;
	logic arst_n;

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	kca_in_if  scan_if ();
	kca_out_if res_if ();

	key_click_autorepeat_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan    (scan_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// requests waiting for the driver, expected reports in arrival order
	kca_item_t pending_q [$];
	kca_res_t  report_q [$];

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned n_err;

	// ------------------------------------------------------------------
	// Predictor: own copy of key words, held key and delays.
	// ------------------------------------------------------------------
	logic [DELAY_W-1:0] cfg_first;
	logic [DELAY_W-1:0] cfg_repeat;
	logic [WORD_W-1:0]  kp_prev0, kp_prev2, kp_cur0, kp_cur2;
	logic               kp_held;
	logic [IDX_W-1:0]   kp_held_idx;
	logic [WORD_W-1:0]  kp_last_ms;
	logic               kp_repeating;

	function automatic kca_res_t predict_report(input kca_item_t it);
		kca_res_t          r;
		logic [WORD_W-1:0] was;
		logic [WORD_W-1:0] now_w;
		logic [WORD_W-1:0] elapsed;
		logic [WORD_W-1:0] lim;
		bit                hit;
		r   = '0;
		hit = 1'b0;
		// forget: only drops the held key, words and time untouched
		if (it.cmd == CMD_FORGET) begin
			kp_held = 1'b0;
			return r;
		end
		kp_prev0 = kp_cur0;
		kp_prev2 = kp_cur2;
		kp_cur0  = it.keys_group0;
		kp_cur2  = it.keys_group2;
		// first key in table order whose bits went from any-high to all-low
		for (int i = 0; i < TBL_KEYS; i++) begin
			was   = TBL_G2[i] ? kp_prev2 : kp_prev0;
			now_w = TBL_G2[i] ? kp_cur2 : kp_cur0;
			if (!hit && (was & TBL_MASK[i]) != '0 && (now_w & TBL_MASK[i]) == '0) begin
				hit          = 1'b1;
				kp_held      = 1'b1;
				kp_held_idx  = IDX_W'(i);
				kp_repeating = 1'b0;
				kp_last_ms   = it.now_ms;
				r.key_valid  = 1'b1;
				r.key_index  = IDX_W'(i);
			end
		end
		if (!hit) begin
			now_w = TBL_G2[kp_held_idx] ? kp_cur2 : kp_cur0;
			if (kp_held && (now_w & TBL_MASK[kp_held_idx]) == '0) begin
				// unsigned wrap-around difference, strictly greater than the delay
				elapsed = it.now_ms - kp_last_ms;
				lim     = kp_repeating ? WORD_W'(cfg_repeat) : WORD_W'(cfg_first);
				if (elapsed > lim) begin
					kp_repeating = 1'b1;
					kp_last_ms   = it.now_ms;
					r.key_valid  = 1'b1;
					r.key_index  = kp_held_idx;
				end
			end else begin
				kp_held     = 1'b0;
				kp_held_idx = '0;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: takes the next request from pending_q once the slot is free.
	// valid gets exactly one NBA per edge when the slot turns over.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		kca_item_t nxt;
		if (!scan_if.valid || scan_if.ready) begin
			if (arst_n && pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt = pending_q.pop_front();
				scan_if.valid       <= 1'b1;
				scan_if.cmd         <= nxt.cmd;
				scan_if.keys_group0 <= nxt.keys_group0;
				scan_if.keys_group2 <= nxt.keys_group2;
				scan_if.now_ms      <= nxt.now_ms;
			end else begin
				scan_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks results against the oldest expectation, then predicts
	// for a request taken at this same edge. Both queue ends live here, so
	// ordering between processes cannot matter.
	// ------------------------------------------------------------------
	int unsigned n_taken;
	int unsigned hold_left;
	bit          hold_done;

	always @(posedge clk) begin
		kca_res_t  want;
		kca_item_t seen;
		if (res_if.valid && res_if.ready) begin
			if (report_q.size() == 0) begin
				n_err++;
				$display("%0t: result with nothing expected: key_valid=%0b key_index=%0d",
					$time, res_if.key_valid, res_if.key_index);
			end else begin
				want = report_q.pop_front();
				if (res_if.key_valid !== want.key_valid) begin
					n_err++;
					$display("%0t: key_valid expected %0b actual %0b",
						$time, want.key_valid, res_if.key_valid);
				end
				if (res_if.key_index !== want.key_index) begin
					n_err++;
					$display("%0t: key_index expected %0d actual %0d",
						$time, want.key_index, res_if.key_index);
				end
			end
		end
		if (scan_if.valid && scan_if.ready) begin
			seen = '{scan_if.cmd, scan_if.keys_group0, scan_if.keys_group2, scan_if.now_ms};
			report_q.push_back(predict_report(seen));
			n_taken++;
		end
		// one long back-pressure stretch while the sender keeps offering
		if (!hold_done && n_taken >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog: any handshake restarts the count
	int unsigned quiet;

	always @(posedge clk) begin
		if ((scan_if.valid && scan_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet <= 0;
		end else if (arst_n) begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Config port: write with a setup and an access phase, then read back.
	// ------------------------------------------------------------------
	task automatic check_reg(input kca_reg_t idx, input logic [DELAY_W-1:0] val);
		logic [31:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'(4 * int'(idx));
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got[DELAY_W-1:0] !== val) begin
			n_err++;
			$display("%0t: register %0d read expected %0d actual %0d",
				$time, idx, val, got[DELAY_W-1:0]);
		end
	endtask

	task automatic write_reg(input kca_reg_t idx, input logic [DELAY_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * int'(idx));
		pwdata  <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// written at this edge
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_FIRST_DELAY)
			cfg_first = val;
		else
			cfg_repeat = val;
		check_reg(idx, val);
	endtask

	// wait until the driver is empty and every report has been taken
	task automatic settle();
		do
			@(negedge clk);
		while (pending_q.size() != 0 || scan_if.valid || report_q.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	logic [WORD_W-1:0] gen_w0, gen_w2, gen_t;

	task automatic push_scan(input logic [WORD_W-1:0] w0, w2, t);
		pending_q.push_back('{CMD_SCAN, w0, w2, t});
	endtask

	task automatic push_forget();
		// key words and time are don't-care on a forget
		pending_q.push_back('{CMD_FORGET, $urandom, $urandom, $urandom});
	endtask

	// Random request built around a running key state: presses and releases
	// of table keys, noise on the other bits, time steps near the delays.
	task automatic add_random(input logic [DELAY_W-1:0] fd, input logic [DELAY_W-1:0] rd);
		int unsigned       pick;
		int unsigned       k;
		int unsigned       span;
		logic [WORD_W-1:0] step;
		pick = $urandom_range(99);
		k    = $urandom_range(TBL_KEYS - 1);
		if (pick < 6) begin
			push_forget();
			return;
		end
		if (pick < 14) begin
			gen_w0 = $urandom;
			gen_w2 = $urandom;
		end else if (pick < 40) begin
			if (TBL_G2[k])
				gen_w2 &= ~TBL_MASK[k];
			else
				gen_w0 &= ~TBL_MASK[k];
		end else if (pick < 62) begin
			if (TBL_G2[k])
				gen_w2 |= TBL_MASK[k];
			else
				gen_w0 |= TBL_MASK[k];
		end else if (pick < 66) begin
			gen_w0 |= KEYBITS0;
			gen_w2 |= KEYBITS2;
		end
		if ($urandom_range(3) == 0) begin
			gen_w0 = (gen_w0 & KEYBITS0) | ($urandom & ~KEYBITS0);
			gen_w2 = (gen_w2 & KEYBITS2) | ($urandom & ~KEYBITS2);
		end
		span = ((fd > rd) ? fd : rd) / 2 + 3;
		case ($urandom_range(9))
			0: step = '0;
			1: step = WORD_W'(fd);
			2: step = WORD_W'(fd) + 1;
			3: step = WORD_W'(rd);
			4: step = WORD_W'(rd) + 1;
			5: step = $urandom;
			default: step = $urandom_range(span);
		endcase
		gen_t += step;
		push_scan(gen_w0, gen_w2, gen_t);
	endtask

	task automatic run_phase(
		input logic [DELAY_W-1:0] fd,
		input logic [DELAY_W-1:0] rd,
		input int unsigned        n,
		input int unsigned        tx,
		input int unsigned        rx
	);
		settle();
		write_reg(REG_FIRST_DELAY, fd);
		write_reg(REG_REPEAT_DELAY, rd);
		tx_idle_pct = tx;
		rx_idle_pct = rx;
		// half the phases start close to the time wrap
		gen_t = $urandom_range(1) ? $urandom : 32'hffff_ffff - $urandom_range(100000);
		@(negedge clk);
		repeat (n) add_random(fd, rd);
	endtask

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		scan_if.valid       = 1'b0;
		scan_if.cmd         = CMD_SCAN;
		scan_if.keys_group0 = '1;
		scan_if.keys_group2 = '1;
		scan_if.now_ms      = '0;
		res_if.ready        = 1'b0;
		tx_idle_pct         = 13;
		rx_idle_pct         = 53;
		n_err               = 0;
		n_taken             = 0;
		hold_left           = 0;
		hold_done           = 1'b0;
		quiet               = 0;

		cfg_first    = 16'd500;
		cfg_repeat   = 16'd175;
		kp_prev0     = '1;
		kp_prev2     = '1;
		kp_cur0      = '1;
		kp_cur2      = '1;
		kp_held      = 1'b0;
		kp_held_idx  = '0;
		kp_last_ms   = '0;
		kp_repeating = 1'b0;
		gen_w0       = '1;
		gen_w2       = '1;
		gen_t        = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// delays out of reset
		check_reg(REG_FIRST_DELAY, 16'd500);
		check_reg(REG_REPEAT_DELAY, 16'd175);
		@(negedge clk);

		// directed: reset delays 500 / 175
		push_scan('1, '1, 32'd0);                           // nothing pressed
		push_scan(~32'h800, '1, 32'd1000);                  // key 0 click
		push_scan(~32'h800, '1, 32'd1500);                  // elapsed == first delay: quiet
		push_scan(~32'h800, '1, 32'd1501);                  // first repeat
		push_scan(~32'h800, '1, 32'd1676);                  // elapsed == repeat delay: quiet
		push_scan(~32'h800, '1, 32'd1677);                  // second repeat
		push_forget();                                      // drop held key
		push_scan(~32'h800, '1, 32'd3000);                  // still down, but forgotten
		push_scan('1, '1, 32'd3001);                        // release
		push_scan('1, ~32'h0004_0000, 32'd4000);            // group 2 bit 18: last table key
		push_scan('1, ~32'h000c_0000, 32'd4100);            // two-bit key wins over key 12
		push_scan('0, '0, 32'hffff_ff00);                   // all low: key 0 first in order
		push_scan('0, '0, 32'h0000_0200);                   // repeat across the time wrap
		push_scan('1, '1, 32'hffff_ffff);                   // release all
		push_scan(~32'h0020_8000, '1, 32'd5000);            // keys 4 and 7 at once: 4 reported
		push_scan(~32'h0020_0000, '1, 32'd5600);            // held key released: record cleared
		push_forget();
		push_scan('1, ~32'h800, 32'd7000);                  // group 2 key 9 click
		push_scan('1, ~32'h800, 32'd7501);                  // and its repeat

		// random phases over a spread of delays, extremes included
		run_phase(16'd0,     16'd0,     70, 13, 53);
		run_phase(16'd65535, 16'd65535, 60, 13, 53);
		run_phase(16'd40,    16'd10,    70, 53, 13);
		run_phase(16'd1,     16'd65535, 60, 53, 13);
		run_phase(DELAY_W'($urandom_range(2000)), DELAY_W'($urandom_range(600)), 70, 0, 0);
		run_phase(16'd500,   16'd175,   70, 0, 0);

		settle();
		if (n_err == 0 && report_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
